### rtl/core/tgsdp_pkg.sv
// Shared constants and types of the ternary group-scaled dot product.
package tgsdp_pkg;

   // Lane and field widths
   localparam int LANES      = 4;
   localparam int ACT_BITS   = 16;
   localparam int CODE_BITS  = 2;
   localparam int CODES_BITS = LANES * CODE_BITS;
   localparam int SCALE_BITS = 16;
   localparam int GROUP_BITS = 24;
   localparam int PROD_BITS  = GROUP_BITS + SCALE_BITS;
   localparam int OUT_BITS   = 48;

   // Item sum grows by one bit per lane doubling, plus one for negation
   localparam int ITEM_BITS  = ACT_BITS + $clog2(LANES) + 1;

   // Row accumulator width default
   localparam int ACC_BITS_DEFAULT = 48;

   // Ternary weight codes
   typedef enum logic [CODE_BITS-1:0] {
      CODE_SUB    = 2'd0,
      CODE_ZERO_A = 2'd1,
      CODE_ADD    = 2'd2,
      CODE_ZERO_B = 2'd3
   } code_type;

   // Registered input word
   typedef struct packed {
      logic [LANES-1:0][ACT_BITS-1:0] activation;
      logic [CODES_BITS-1:0]          weight_codes;
      logic [SCALE_BITS-1:0]          group_scale;
      logic                           group_end;
      logic                           row_end;
   } in_word_type;

   // Finished group total with its scale
   typedef struct packed {
      logic [GROUP_BITS-1:0] total;
      logic [SCALE_BITS-1:0] scale;
      logic                  row_end;
   } group_word_type;

   // Scaled group contribution
   typedef struct packed {
      logic [PROD_BITS-1:0] prod;
      logic                 row_end;
   } prod_word_type;

endpackage

### rtl/core/tgsdp_if.sv
// Valid/ready channel interfaces for the request and response words.
interface tgsdp_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [tgsdp_pkg::ACT_BITS-1:0]  activation_0;
   logic signed [tgsdp_pkg::ACT_BITS-1:0]  activation_1;
   logic signed [tgsdp_pkg::ACT_BITS-1:0]  activation_2;
   logic signed [tgsdp_pkg::ACT_BITS-1:0]  activation_3;
   logic [tgsdp_pkg::CODES_BITS-1:0]       weight_codes;
   logic signed [tgsdp_pkg::SCALE_BITS-1:0] group_scale;
   logic                                   group_end;
   logic                                   row_end;

   modport source (
      output valid, activation_0, activation_1, activation_2, activation_3,
             weight_codes, group_scale, group_end, row_end,
      input  ready
   );
   modport sink (
      input  valid, activation_0, activation_1, activation_2, activation_3,
             weight_codes, group_scale, group_end, row_end,
      output ready
   );
endinterface

interface tgsdp_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [tgsdp_pkg::OUT_BITS-1:0] row_sum;
   logic                                  overflowed;

   modport source (output valid, row_sum, overflowed, input ready);
   modport sink (input valid, row_sum, overflowed, output ready);
endinterface

### rtl/core/tgsdp_group.sv
// Ternary lane sum and wrapping group total; passes finished groups on.
module tgsdp_group (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  tgsdp_pkg::in_word_type    in_word,
   output logic                      in_ready,
   output logic                      grp_valid,
   output tgsdp_pkg::group_word_type grp_word,
   input  logic                      grp_ready
);

   logic signed [tgsdp_pkg::ITEM_BITS-1:0]  item_sum;
   logic signed [tgsdp_pkg::GROUP_BITS-1:0] group_sum;
   logic signed [tgsdp_pkg::GROUP_BITS-1:0] group_total_ff, group_total_in;
   logic                                    grp_valid_ff, grp_valid_in;
   tgsdp_pkg::group_word_type               grp_word_ff, grp_word_in;
   logic                                    take;
   logic                                    ends;

   // Add or subtract each lane by its code
   always_comb begin
      tgsdp_pkg::code_type                    code;
      logic signed [tgsdp_pkg::ITEM_BITS-1:0] act;
      item_sum = '0;
      for (int i = 0; i < tgsdp_pkg::LANES; i++) begin
         code = tgsdp_pkg::code_type'(in_word.weight_codes[i*tgsdp_pkg::CODE_BITS +:
                                                           tgsdp_pkg::CODE_BITS]);
         act  = tgsdp_pkg::ITEM_BITS'($signed(in_word.activation[i]));
         unique case (code)
            tgsdp_pkg::CODE_ADD: item_sum = item_sum + act;
            tgsdp_pkg::CODE_SUB: item_sum = item_sum - act;
            default:             item_sum = item_sum;
         endcase
      end
   end

   // Wrap the group total at its width
   assign group_sum = group_total_ff + tgsdp_pkg::GROUP_BITS'(item_sum);

   assign in_ready = !grp_valid_ff || grp_ready;
   assign take     = in_valid && in_ready;
   assign ends     = in_word.group_end || in_word.row_end;

   // Close the group on either end mark, else keep summing
   always_comb begin
      group_total_in      = group_total_ff;
      grp_valid_in        = grp_valid_ff && !grp_ready;
      grp_word_in         = grp_word_ff;
      if (take) begin
         grp_valid_in = ends;
         if (ends) begin
            group_total_in      = '0;
            grp_word_in.total   = group_sum;
            grp_word_in.scale   = in_word.group_scale;
            grp_word_in.row_end = in_word.row_end;
         end else begin
            group_total_in = group_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_total_ff <= '0;
         grp_valid_ff   <= 1'b0;
      end else begin
         group_total_ff <= group_total_in;
         grp_valid_ff   <= grp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      grp_word_ff <= grp_word_in;
   end

   assign grp_valid = grp_valid_ff;
   assign grp_word  = grp_word_ff;

endmodule

### rtl/core/tgsdp_scale.sv
// Group scale multiply with a registered product.
module tgsdp_scale (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      grp_valid,
   input  tgsdp_pkg::group_word_type grp_word,
   output logic                      grp_ready,
   output logic                      prod_valid,
   output tgsdp_pkg::prod_word_type  prod_word,
   input  logic                      prod_ready
);

   logic signed [tgsdp_pkg::GROUP_BITS-1:0] total_s;
   logic signed [tgsdp_pkg::SCALE_BITS-1:0] scale_s;
   logic signed [tgsdp_pkg::PROD_BITS-1:0]  prod_s;
   logic                                    prod_valid_ff, prod_valid_in;
   tgsdp_pkg::prod_word_type                prod_word_ff, prod_word_in;
   logic                                    take;

   // Exact signed product, Q16.8 by Q4.12 gives Q.20
   assign total_s = $signed(grp_word.total);
   assign scale_s = $signed(grp_word.scale);
   assign prod_s  = tgsdp_pkg::PROD_BITS'(total_s) * tgsdp_pkg::PROD_BITS'(scale_s);

   assign grp_ready = !prod_valid_ff || prod_ready;
   assign take      = grp_valid && grp_ready;

   // Load on take, drop once consumed
   always_comb begin
      prod_valid_in = take ? 1'b1 : (prod_valid_ff && !prod_ready);
      prod_word_in  = prod_word_ff;
      if (take) begin
         prod_word_in.prod    = prod_s;
         prod_word_in.row_end = grp_word.row_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_word_ff <= prod_word_in;
   end

   assign prod_valid = prod_valid_ff;
   assign prod_word  = prod_word_ff;

endmodule

### rtl/core/tgsdp_accum.sv
// Saturating row accumulator and the response register.
module tgsdp_accum #(
   parameter int ACC_BITS = tgsdp_pkg::ACC_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  prod_valid,
   input  tgsdp_pkg::prod_word_type              prod_word,
   output logic                                  prod_ready,
   output logic                                  rsp_valid,
   output logic signed [tgsdp_pkg::OUT_BITS-1:0] rsp_row_sum,
   output logic                                  rsp_overflowed,
   input  logic                                  rsp_ready
);

   localparam int WIDE_BITS = (ACC_BITS > tgsdp_pkg::OUT_BITS) ? ACC_BITS
                                                                : tgsdp_pkg::OUT_BITS;

   logic signed [ACC_BITS-1:0]              row_total_ff, row_total_in;
   logic                                    sat_ff, sat_in;
   logic signed [tgsdp_pkg::PROD_BITS-1:0]  prod_s;
   logic signed [ACC_BITS:0]                sum;
   logic                                    ovf;
   logic signed [ACC_BITS-1:0]              acc_next;
   logic signed [WIDE_BITS-1:0]             acc_wide;
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic signed [tgsdp_pkg::OUT_BITS-1:0]   row_sum_ff, row_sum_in;
   logic                                    overflowed_ff, overflowed_in;
   logic                                    take;

   // Add with one guard bit, clamp when the guard disagrees
   assign prod_s = $signed(prod_word.prod);
   assign sum    = (ACC_BITS + 1)'(row_total_ff) + (ACC_BITS + 1)'(prod_s);
   assign ovf    = sum[ACC_BITS] != sum[ACC_BITS-1];

   always_comb begin
      if (!ovf) begin
         acc_next = sum[ACC_BITS-1:0];
      end else if (sum[ACC_BITS]) begin
         acc_next = {1'b1, {(ACC_BITS-1){1'b0}}};
      end else begin
         acc_next = {1'b0, {(ACC_BITS-1){1'b1}}};
      end
   end

   // Fit the accumulator to the output width
   assign acc_wide = WIDE_BITS'(acc_next);

   // A row end needs a free response slot
   assign prod_ready = !prod_word.row_end || !rsp_valid_ff || rsp_ready;
   assign take       = prod_valid && prod_ready;

   always_comb begin
      row_total_in  = row_total_ff;
      sat_in        = sat_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      row_sum_in    = row_sum_ff;
      overflowed_in = overflowed_ff;
      if (take) begin
         if (prod_word.row_end) begin
            row_total_in  = '0;
            sat_in        = 1'b0;
            rsp_valid_in  = 1'b1;
            row_sum_in    = acc_wide[tgsdp_pkg::OUT_BITS-1:0];
            overflowed_in = sat_ff || ovf;
         end else begin
            row_total_in = acc_next;
            sat_in       = sat_ff || ovf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_total_ff <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_total_ff <= row_total_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_sum_ff    <= row_sum_in;
      overflowed_ff <= overflowed_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row_sum    = row_sum_ff;
   assign rsp_overflowed = overflowed_ff;

endmodule

### rtl/core/ternary_group_scaled_dot_product.sv
// Top level of the ternary-weight, group-scaled row dot product.
// Each request word carries four Q8.8 activations and four 2-bit weight
// codes (lane 0 in bits 1:0; code 0 subtracts, code 2 adds, 1 and 3 add
// nothing). Words are summed into a 24-bit wrapping group total; a group end
// (or row end) multiplies that total by the word's Q4.12 scale and adds the
// Q.20 product into a saturating ACC_BITS-bit row accumulator. A row end
// emits one response word with the 48-bit row sum and a saturation flag,
// then clears all state. One request word is taken every clock while the
// response side is not back-pressuring; the rate is set by the
// group-total adder loop and the row-accumulator adder loop, each a single
// add per cycle. A row-end word passes through the input register, the group
// register, the product register and the response register, in that order,
// before its response word is valid. Back-pressure on the response side
// fills the free stages before the request side stalls.
module ternary_group_scaled_dot_product #(
   parameter int ACC_BITS = tgsdp_pkg::ACC_BITS_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   tgsdp_req_if.sink   req_chan,
   tgsdp_rsp_if.source rsp_chan
);

   logic                      in_valid_ff, in_valid_in;
   tgsdp_pkg::in_word_type    in_word_ff, in_word_in;
   logic                      in_ready;
   logic                      req_take;
   logic                      grp_valid;
   tgsdp_pkg::group_word_type grp_word;
   logic                      grp_ready;
   logic                      prod_valid;
   tgsdp_pkg::prod_word_type  prod_word;
   logic                      prod_ready;

   // Input register: take a word whenever the group stage can drain it
   assign req_chan.ready = !in_valid_ff || in_ready;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = req_take ? 1'b1 : (in_valid_ff && !in_ready);
      in_word_in  = in_word_ff;
      if (req_take) begin
         in_word_in.activation[0] = req_chan.activation_0;
         in_word_in.activation[1] = req_chan.activation_1;
         in_word_in.activation[2] = req_chan.activation_2;
         in_word_in.activation[3] = req_chan.activation_3;
         in_word_in.weight_codes  = req_chan.weight_codes;
         in_word_in.group_scale   = req_chan.group_scale;
         in_word_in.group_end     = req_chan.group_end;
         in_word_in.row_end       = req_chan.row_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_word_ff <= in_word_in;
   end

   // Lane sum and group total
   tgsdp_group u_group (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_word   (in_word_ff),
      .in_ready  (in_ready),
      .grp_valid (grp_valid),
      .grp_word  (grp_word),
      .grp_ready (grp_ready)
   );

   // Group scale product
   tgsdp_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .grp_valid  (grp_valid),
      .grp_word   (grp_word),
      .grp_ready  (grp_ready),
      .prod_valid (prod_valid),
      .prod_word  (prod_word),
      .prod_ready (prod_ready)
   );

   // Row accumulator and response register
   tgsdp_accum #(
      .ACC_BITS (ACC_BITS)
   ) u_accum (
      .clock          (clock),
      .reset          (reset),
      .prod_valid     (prod_valid),
      .prod_word      (prod_word),
      .prod_ready     (prod_ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_row_sum    (rsp_chan.row_sum),
      .rsp_overflowed (rsp_chan.overflowed),
      .rsp_ready      (rsp_chan.ready)
   );

endmodule
